// ===== design/lcbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcbc_pkg: shared types and constants
// Widths of the binary-to-BCD converter, brand codes and sequencer states.
// ----------------------------------------------------------------------------
package lcbc_pkg;

    localparam int CARD_W      = 63;
    localparam int BIN_W       = 64;              // card number padded to whole chunks
    localparam int CHUNK       = 4;               // binary bits folded in per cycle
    localparam int BCD_DIGITS  = 19;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int CONV_CYCLES = BIN_W / CHUNK;
    localparam int IDX_W       = 5;
    localparam int MAX_DIGITS  = 19;              // most digits a valid number may carry

    localparam logic [IDX_W-1:0] CONV_LAST = IDX_W'(CONV_CYCLES - 1);
    localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(BCD_DIGITS - 1);

    localparam logic [3:0] DIGIT_FIVE  = 4'd5;
    localparam logic [3:0] DIGIT_NINE  = 4'd9;
    localparam logic [3:0] DIGIT_TEN   = 4'd10;

    localparam logic [4:0] LEN_VISA_SHORT = 5'd13;
    localparam logic [4:0] LEN_AMEX       = 5'd15;
    localparam logic [4:0] LEN_SIXTEEN    = 5'd16;

    localparam logic [3:0] LEAD_AMEX_T   = 4'd3;
    localparam logic [3:0] LEAD_AMEX_U0  = 4'd4;
    localparam logic [3:0] LEAD_AMEX_U1  = 4'd7;
    localparam logic [3:0] LEAD_VISA_T   = 4'd4;
    localparam logic [3:0] LEAD_MC_T     = 4'd5;
    localparam logic [3:0] LEAD_MC_U_MIN = 4'd1;
    localparam logic [3:0] LEAD_MC_U_MAX = 4'd5;

    typedef enum logic [1:0] {
        BRAND_INVALID    = 2'd0,
        BRAND_AMEX       = 2'd1,
        BRAND_VISA       = 2'd2,
        BRAND_MASTERCARD = 2'd3
    } t_brand;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage
`default_nettype wire

// ===== design/luhn_card_brand_classifier_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// luhn_card_brand_classifier_core: Luhn mod-10 check and card brand decode
//
//   channel  | handshake             | word
//   ---------+-----------------------+---------------------------------------
//   command  | start / busy          | i_card_number[62:0]
//   result   | o_valid (1-cycle)     | o_brand, o_luhn_ok, o_digit_count
//
// After the accept edge the sequencer passes CONV, where the shift-and-add-3
// unit folds in 4 bits a cycle, SCAN, which feeds one BCD digit a cycle into
// the Luhn accumulator, and DONE, which decodes the brand and registers the result.
// busy is high from the cycle after accept until the result strobe; a new
// start is taken in the strobe cycle, so a new word is not accepted while
// the last one is still in work. Results cannot be stalled.
// Reset (synchronous, active low) returns the sequencer to idle.
// ----------------------------------------------------------------------------
module luhn_card_brand_classifier_core import lcbc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [CARD_W-1:0] i_card_number,
    output logic                   o_valid,
    output logic [1:0]             o_brand,
    output logic                   o_luhn_ok,
    output logic [4:0]             o_digit_count
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [BIN_W-1:0]  r_bin, n_bin;
    logic [BCD_W-1:0]  r_bcd, n_bcd;
    logic [4:0]        r_count, n_count;
    logic [3:0]        r_sum, n_sum;
    logic              r_have_lead, n_have_lead;
    logic [3:0]        r_lead_t, n_lead_t;
    logic [3:0]        r_lead_u, n_lead_u;
    logic              r_valid, n_valid;
    logic [1:0]        r_brand, n_brand;
    logic              r_ok, n_ok;
    logic [4:0]        r_dcount, n_dcount;

    logic [BCD_W-1:0]  dab_bcd;
    logic [3:0]        digit;
    logic [4:0]        dbl;
    logic [3:0]        term;
    logic [4:0]        acc;
    logic [4:0]        cnt_fin;
    logic              ok_fin;
    t_brand            brand_fin;

    lcbc_dabble u_dabble (
        .i_bcd  (r_bcd),
        .i_bits (r_bin[BIN_W-1 -: CHUNK]),
        .o_bcd  (dab_bcd)
    );

    // Luhn digit term
    always_comb begin
        digit = r_bcd[3:0];
        dbl   = {digit, 1'b0};
        if (!r_idx[0]) begin
            term = digit;
        end else if (dbl > {1'b0, DIGIT_NINE}) begin
            term = 4'(dbl - {1'b0, DIGIT_NINE});
        end else begin
            term = dbl[3:0];
        end
        acc = {1'b0, r_sum} + {1'b0, term};
    end

    // Brand decode
    always_comb begin
        cnt_fin   = (r_count == 5'd0) ? 5'd1 : r_count;
        ok_fin    = (r_sum == 4'd0) && (cnt_fin <= 5'(MAX_DIGITS));
        brand_fin = BRAND_INVALID;
        if (ok_fin) begin
            if (cnt_fin == LEN_AMEX && r_lead_t == LEAD_AMEX_T &&
                (r_lead_u == LEAD_AMEX_U0 || r_lead_u == LEAD_AMEX_U1)) begin
                brand_fin = BRAND_AMEX;
            end else if (r_lead_t == LEAD_VISA_T &&
                         (cnt_fin == LEN_VISA_SHORT || cnt_fin == LEN_SIXTEEN)) begin
                brand_fin = BRAND_VISA;
            end else if (cnt_fin == LEN_SIXTEEN && r_lead_t == LEAD_MC_T &&
                         r_lead_u >= LEAD_MC_U_MIN && r_lead_u <= LEAD_MC_U_MAX) begin
                brand_fin = BRAND_MASTERCARD;
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_count     = r_count;
        n_sum       = r_sum;
        n_have_lead = r_have_lead;
        n_lead_t    = r_lead_t;
        n_lead_u    = r_lead_u;
        n_valid     = 1'b0;
        n_brand     = r_brand;
        n_ok        = r_ok;
        n_dcount    = r_dcount;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state     = S_CONV;
                    n_idx       = '0;
                    n_bin       = {1'b0, i_card_number};
                    n_bcd       = '0;
                    n_count     = '0;
                    n_sum       = '0;
                    n_have_lead = 1'b0;
                    n_lead_t    = '0;
                    n_lead_u    = '0;
                end
            end
            S_CONV: begin
                n_bcd = dab_bcd;
                n_bin = {r_bin[BIN_W-CHUNK-1:0], {CHUNK{1'b0}}};
                n_idx = r_idx + 1'b1;
                if (r_idx == CONV_LAST) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            S_SCAN: begin
                if (r_bcd != '0) begin
                    n_count = r_idx + 1'b1;
                end
                if (!r_have_lead && r_bcd[BCD_W-1:8] == '0) begin
                    n_have_lead = 1'b1;
                    n_lead_t    = r_bcd[7:4];
                    n_lead_u    = r_bcd[3:0];
                end
                n_sum = (acc >= {1'b0, DIGIT_TEN}) ? 4'(acc - {1'b0, DIGIT_TEN}) : acc[3:0];
                n_bcd = {4'd0, r_bcd[BCD_W-1:4]};
                n_idx = r_idx + 1'b1;
                if (r_idx == SCAN_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state  = S_IDLE;
                n_valid  = 1'b1;
                n_brand  = brand_fin;
                n_ok     = ok_fin;
                n_dcount = cnt_fin;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_bin       <= n_bin;
        r_bcd       <= n_bcd;
        r_count     <= n_count;
        r_sum       <= n_sum;
        r_have_lead <= n_have_lead;
        r_lead_t    <= n_lead_t;
        r_lead_u    <= n_lead_u;
        r_brand     <= n_brand;
        r_ok        <= n_ok;
        r_dcount    <= n_dcount;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_brand       = r_brand;
    assign o_luhn_ok     = r_ok;
    assign o_digit_count = r_dcount;

endmodule
`default_nettype wire

// ===== design/lcbc_dabble.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcbc_dabble: four shift-and-add-3 steps of binary-to-BCD conversion
// Folds CHUNK binary bits, MSB first, into a 19-digit BCD accumulator.
// ----------------------------------------------------------------------------
module lcbc_dabble import lcbc_pkg::*; (
    input  wire logic [BCD_W-1:0] i_bcd,
    input  wire logic [CHUNK-1:0] i_bits,
    output logic      [BCD_W-1:0] o_bcd
);

    always_comb begin
        logic [BCD_W-1:0] acc;
        acc = i_bcd;
        for (int k = 0; k < CHUNK; k++) begin
            for (int d = 0; d < BCD_DIGITS; d++) begin
                if (acc[4*d +: 4] >= DIGIT_FIVE) begin
                    acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], i_bits[CHUNK-1-k]};
        end
        o_bcd = acc;
    end

endmodule
`default_nettype wire
